// ===== src/fipd_pkg.sv =====
package fipd_pkg;

    localparam int FLOAT_W    = 32;
    localparam int EXP_W      = 8;
    localparam int FRAC_W     = 23;
    localparam int MANT_W     = FRAC_W + 1;
    localparam int DIGIT_W    = 4;
    // bit counter: holds up to 129 integer bits (exponent field 255)
    localparam int CNT_W      = 8;

    localparam logic [EXP_W-1:0]   EXP_BIAS   = 8'd127;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;

endpackage

// ===== src/fipd_dabble.sv =====
module fipd_dabble #(
    parameter int NUM_DIGITS = 40
) (
    input  logic [NUM_DIGITS*fipd_pkg::DIGIT_W-1:0] i_bcd,
    input  logic                                    i_bit,
    output logic [NUM_DIGITS*fipd_pkg::DIGIT_W-1:0] o_bcd
);
    import fipd_pkg::*;

    logic [NUM_DIGITS*DIGIT_W-1:0] adj;

    // correct every digit that would overflow on doubling
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (i_bcd[d*DIGIT_W +: DIGIT_W] >= DABBLE_MIN) begin
                adj[d*DIGIT_W +: DIGIT_W] = i_bcd[d*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
            end else begin
                adj[d*DIGIT_W +: DIGIT_W] = i_bcd[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // shift the next binary bit in; the carry out of the top digit drops
    assign o_bcd = {adj[NUM_DIGITS*DIGIT_W-2:0], i_bit};

endmodule

// ===== src/float_integer_part_to_decimal_core.sv =====
// Decimal digits of the integer part of a single-precision float. A request on the
// input channel carries a raw 32-bit pattern; the sign bit is ignored, a negative
// unbiased exponent (zero, subnormals, |x| < 1) gives the single digit 0, and an
// exponent field of 255 is taken as an ordinary exponent of 128. The result channel
// then delivers the digits most significant first, one request per digit, leading
// zeros suppressed, with o_last_digit set on the least significant digit. After the
// input is taken, one shared double-dabble step runs once per integer bit, e+1 bits
// for unbiased exponent e (at most 129), then the BCD register is walked one digit a
// cycle while the output side does not stall. o_ready is high only between
// conversions; the last digit may still wait in the output register while the next
// request is taken. Only the low MAX_INT_BITS integer bits are converted, and digits
// beyond MAX_DIGITS drop off the top (neither happens at the defaults).
module float_integer_part_to_decimal_core #(
    parameter int MAX_INT_BITS = 129,
    parameter int MAX_DIGITS   = 40
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [fipd_pkg::FLOAT_W-1:0]  i_float_bits,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fipd_pkg::DIGIT_W-1:0]  o_digit,
    output logic                          o_last_digit
);
    import fipd_pkg::*;

    localparam int BCD_W     = MAX_DIGITS * DIGIT_W;
    localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [MANT_W-1:0]      r_mant;
    logic [CNT_W-1:0]       r_bits_left;
    logic [BCD_W-1:0]       r_bcd;
    logic [DIG_CNT_W-1:0]   r_dig_left;
    logic                   r_started;
    logic                   r_out_valid;
    logic [DIGIT_W-1:0]     r_digit;
    logic                   r_last;

    logic [EXP_W-1:0]       expf;
    logic [CNT_W-1:0]       int_bits;
    logic [BCD_W-1:0]       bcd_step;
    logic [DIGIT_W-1:0]     top_digit;
    logic                   out_free;
    logic                   dig_last;
    logic                   dig_skip;
    logic                   dig_fire;

    assign expf      = i_float_bits[FLOAT_W-2 -: EXP_W];
    // integer width: unbiased exponent plus one
    assign int_bits  = CNT_W'(expf) - CNT_W'(EXP_BIAS - 1'b1);
    assign top_digit = r_bcd[BCD_W-1 -: DIGIT_W];
    assign out_free  = !r_out_valid || i_ready;
    assign dig_last  = (r_dig_left == DIG_CNT_W'(1));
    // leading zero: drop it without a request
    assign dig_skip  = !r_started && (top_digit == '0) && !dig_last;
    // load the next digit into the output register
    assign dig_fire  = (r_state == S_EMIT) && !dig_skip && out_free;

    // shared shift-and-correct unit, one integer bit per cycle
    fipd_dabble #(
        .NUM_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .i_bcd (r_bcd),
        .i_bit (r_mant[MANT_W-1]),
        .o_bcd (bcd_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
            r_bits_left <= '0;
            r_dig_left  <= '0;
        end else begin
            // hold the digit until taken; a new digit replaces it on the same edge
            if (dig_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mant    <= {1'b1, i_float_bits[FRAC_W-1:0]};
                        r_bcd     <= '0;
                        r_started <= 1'b0;
                        if (expf < EXP_BIAS) begin
                            // integer part is zero: emit one 0
                            r_dig_left <= DIG_CNT_W'(1);
                            r_state    <= S_EMIT;
                        end else begin
                            r_bits_left <= int_bits;
                            r_dig_left  <= DIG_CNT_W'(MAX_DIGITS);
                            r_state     <= S_CONV;
                        end
                    end
                end
                S_CONV: begin
                    // advance through the integer bits, top first; bits above
                    // MAX_INT_BITS are shifted past without a step
                    r_mant      <= {r_mant[MANT_W-2:0], 1'b0};
                    r_bits_left <= r_bits_left - 1'b1;
                    if (r_bits_left <= CNT_W'(MAX_INT_BITS)) begin
                        r_bcd <= bcd_step;
                    end
                    if (r_bits_left == CNT_W'(1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (dig_skip) begin
                        r_bcd      <= {r_bcd[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
                        r_dig_left <= r_dig_left - 1'b1;
                    end else if (out_free) begin
                        r_digit     <= top_digit;
                        r_last      <= dig_last;
                        r_started   <= 1'b1;
                        r_bcd       <= {r_bcd[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
                        r_dig_left  <= r_dig_left - 1'b1;
                        if (dig_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_digit      = r_digit;
    assign o_last_digit = r_last;

    a_digit_is_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit <= DIGIT_W'(9)))
        else $error("digit out of decimal range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready after accepting a request");

    a_conv_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> (r_bits_left != '0))
        else $error("conversion running with no bits left");

    a_emit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_dig_left != '0))
        else $error("emission running with no digits left");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_valid) && o_last_digit) |-> (r_state == S_IDLE))
        else $error("last digit issued while conversion still active");

endmodule
